[rtl/ftc_pkg.sv]
// Shared types and constants of the flow template cache.
// Used by ftc_cell and flow_template_cache_core; depends on nothing.
package ftc_pkg;

    localparam int DEF_TEMPLATES  = 64;
    localparam int DEF_MAX_FIELDS = 32;

    localparam int SRC_W  = 32;
    localparam int TID_W  = 16;
    localparam int TYPE_W = 16;
    localparam int FLEN_W = 16;
    localparam int FIDX_W = 8;
    localparam int LEN_W  = 21;
    localparam int OCNT_W = 6;
    localparam int OP_W   = 2;
    localparam int STS_W  = 3;

    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = OP_W;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = STS_W;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [OP_W-1:0] OP_OPEN   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam logic [STS_W-1:0] STS_OK          = 3'd0;
    localparam logic [STS_W-1:0] STS_PRESENT     = 3'd1;
    localparam logic [STS_W-1:0] STS_TABLE_FULL  = 3'd2;
    localparam logic [STS_W-1:0] STS_NOT_FOUND   = 3'd3;
    localparam logic [STS_W-1:0] STS_BAD_INDEX   = 3'd4;
    localparam logic [STS_W-1:0] STS_NONE_OPEN   = 3'd5;
    localparam logic [STS_W-1:0] STS_FIELDS_FULL = 3'd6;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [TID_W-1:0] tid;
    } ftc_key_t;

    typedef struct packed {
        logic hit;
        logic take;
    } ftc_cell_stat_t;

    typedef struct packed {
        logic [TYPE_W-1:0] ftype;
        logic [FLEN_W-1:0] flen;
        logic [LEN_W-1:0]  offset;
    } ftc_field_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [LEN_W-1:0]  offset;
        logic [OCNT_W-1:0] count;
        logic [LEN_W-1:0]  length;
        logic [TYPE_W-1:0] ftype;
        logic [FLEN_W-1:0] flen;
    } ftc_result_t;

endpackage

[rtl/ftc_cell.sv]
// One template slot of the cache row: key, field count, record length, valid.
// Compares a broadcast key and passes the free-slot carry to its upper neighbor.
// Depends on ftc_pkg.
module ftc_cell #(
    parameter int CNT_W = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmp_en,
    input  ftc_pkg::ftc_key_t            cmp_key,
    input  logic                         wr_en,
    input  ftc_pkg::ftc_key_t            wr_key,
    input  logic [CNT_W-1:0]             wr_count,
    input  logic [ftc_pkg::LEN_W-1:0]    wr_length,
    input  logic                         free_in,
    output logic                         free_out,
    output ftc_pkg::ftc_cell_stat_t      stat,
    output logic [CNT_W-1:0]             count,
    output logic [ftc_pkg::LEN_W-1:0]    length
);
    import ftc_pkg::*;

    logic             valid_reg;
    logic             hit_reg;
    ftc_key_t         key_reg;
    logic [CNT_W-1:0] count_reg;
    logic [LEN_W-1:0] length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg <= 1'b1;
            end
            if (cmp_en)
            begin
                hit_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg    <= wr_key;
            count_reg  <= wr_count;
            length_reg <= wr_length;
        end
    end

    assign free_out  = free_in | ~valid_reg;
    assign stat.hit  = hit_reg;
    assign stat.take = ~valid_reg & ~free_in;
    assign count     = count_reg;
    assign length    = length_reg;

endmodule

[rtl/flow_template_cache_core.sv]
// Flow template cache top level: cell row, field memory, sequencer, output word.
// Depends on ftc_pkg and ftc_cell.
//
// Usage:
//   Input words arrive on s_* : tuser carries the operation (open, append,
//   commit, query), tdata the key, field type/length and field index.
//   Every input word yields exactly one output word on m_*: tuser carries
//   the status, tdata the offset, field count, record length and, for a
//   query, the stored field type and length.
//   Sequence: the cell row compares the key at the accept edge, the gather
//   cycle collects hit data and the lowest free slot, and the execute cycle
//   updates state and loads the output word; a query that hits a stored
//   field first goes through a read state for the registered field memory
//   read. One item is in work at a time: the input takes no new word until
//   the last one has been loaded into the output register.
//   Reset clears all slot valid bits and the open template; the field memory
//   is not cleared and needs no sweep. If the receiver stalls, the output word
//   holds; the next item is still taken and processed up to its execute cycle
//   (for a query that hits, its read state) and waits until the output frees.
module flow_template_cache_core #(
    parameter int TEMPLATES  = ftc_pkg::DEF_TEMPLATES,
    parameter int MAX_FIELDS = ftc_pkg::DEF_MAX_FIELDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // source_id[31:0], template_id[47:32], field_type[63:48],
    // field_length[79:64], field_index[87:80]
    input  logic [ftc_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation[1:0]
    input  logic [ftc_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // field_offset[20:0], field_count[26:21], record_length[47:27],
    // found_type[63:48], found_length[79:64]
    output logic [ftc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic [ftc_pkg::OUT_USER_W-1:0]    m_tuser
);
    import ftc_pkg::*;

    localparam int SLOT_W = $clog2(TEMPLATES);
    localparam int CNT_W  = $clog2(MAX_FIELDS + 1);
    localparam int DEPTH  = TEMPLATES * MAX_FIELDS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GATHER = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [OP_W-1:0]   op_reg;
    logic [SRC_W-1:0]  src_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [TYPE_W-1:0] ftype_reg;
    logic [FLEN_W-1:0] flen_reg;
    logic [FIDX_W-1:0] fidx_reg;

    logic              found_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    logic [CNT_W-1:0]  found_count_reg;
    logic [LEN_W-1:0]  found_len_reg;
    logic              free_any_reg;
    logic [SLOT_W-1:0] free_slot_reg;

    logic              open_flag_reg;
    logic [SLOT_W-1:0] open_slot_reg;
    logic [SRC_W-1:0]  open_src_reg;
    logic [TID_W-1:0]  open_tid_reg;
    logic [CNT_W-1:0]  open_count_reg;
    logic [LEN_W-1:0]  open_len_reg;

    logic        out_valid_reg;
    ftc_result_t out_reg;
    ftc_field_t  rdata_reg;
    ftc_field_t  mem [DEPTH];

    logic              accept;
    logic              out_free;
    ftc_key_t          cmp_key;
    ftc_key_t          open_key;
    ftc_cell_stat_t    stat [TEMPLATES];
    logic [CNT_W-1:0]  cell_count [TEMPLATES];
    logic [LEN_W-1:0]  cell_len [TEMPLATES];
    logic [TEMPLATES:0] free_chain;
    logic [TEMPLATES-1:0] cell_we;
    logic [TEMPLATES-1:0] hit_vec;
    logic [TEMPLATES-1:0] take_vec;

    logic              g_found;
    logic [SLOT_W-1:0] g_slot;
    logic [CNT_W-1:0]  g_count;
    logic [LEN_W-1:0]  g_len;
    logic [SLOT_W-1:0] g_take_slot;

    ftc_result_t       res_exec;
    ftc_result_t       res_read;
    logic              start_read;
    logic              set_open;
    logic              clr_open;
    logic              app_upd;
    logic              cell_wr;
    logic              app_wr;
    logic              exec_fire;
    logic              load_exec;
    logic              load_read;
    logic              mem_we;
    logic              mem_re;
    logic [LEN_W:0]    app_sum;
    logic [LEN_W-1:0]  app_len;
    logic              bad_index;
    logic [SLOT_W-1:0] slot_sel;
    logic [ADDR_W-1:0] idx_sel;
    logic [ADDR_W-1:0] mem_addr;
    ftc_field_t        mem_wdata;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign open_key.src = open_src_reg;
    assign open_key.tid = open_tid_reg;

    always_comb
    begin
        if (s_tuser == OP_COMMIT)
        begin
            cmp_key = open_key;
        end
        else
        begin
            cmp_key.src = s_tdata[31:0];
            cmp_key.tid = s_tdata[47:32];
        end
    end

    assign free_chain[0] = 1'b0;

    for (genvar gi = 0; gi < TEMPLATES; gi++)
    begin : g_cell
        assign cell_we[gi]  = cell_wr && exec_fire && (open_slot_reg == SLOT_W'(gi));
        assign hit_vec[gi]  = stat[gi].hit;
        assign take_vec[gi] = stat[gi].take;

        ftc_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmp_en    (accept),
            .cmp_key   (cmp_key),
            .wr_en     (cell_we[gi]),
            .wr_key    (open_key),
            .wr_count  (open_count_reg),
            .wr_length (open_len_reg),
            .free_in   (free_chain[gi]),
            .free_out  (free_chain[gi+1]),
            .stat      (stat[gi]),
            .count     (cell_count[gi]),
            .length    (cell_len[gi])
        );
    end

    always_comb
    begin
        g_found     = 1'b0;
        g_slot      = '0;
        g_count     = '0;
        g_len       = '0;
        g_take_slot = '0;
        for (int i = 0; i < TEMPLATES; i++)
        begin
            if (stat[i].hit)
            begin
                g_found = 1'b1;
                g_slot  = g_slot | SLOT_W'(i);
                g_count = g_count | cell_count[i];
                g_len   = g_len | cell_len[i];
            end
            if (stat[i].take)
            begin
                g_take_slot = g_take_slot | SLOT_W'(i);
            end
        end
    end

    assign app_sum   = {1'b0, open_len_reg} + (LEN_W + 1)'(flen_reg);
    assign app_len   = app_sum[LEN_W] ? LEN_MAX : app_sum[LEN_W-1:0];
    assign bad_index = (32'(fidx_reg) >= 32'(found_count_reg)) || (32'(fidx_reg) >= MAX_FIELDS);

    always_comb
    begin
        res_exec   = '0;
        start_read = 1'b0;
        set_open   = 1'b0;
        clr_open   = 1'b0;
        app_upd    = 1'b0;
        cell_wr    = 1'b0;
        app_wr     = 1'b0;
        unique case (op_reg)
            OP_OPEN:
            begin
                if (found_reg)
                begin
                    res_exec.status = STS_PRESENT;
                end
                else if (!free_any_reg)
                begin
                    res_exec.status = STS_TABLE_FULL;
                end
                else
                begin
                    res_exec.status = STS_OK;
                    set_open        = 1'b1;
                end
            end
            OP_APPEND:
            begin
                if (!open_flag_reg)
                begin
                    res_exec.status = STS_NONE_OPEN;
                end
                else if (open_count_reg >= CNT_W'(MAX_FIELDS))
                begin
                    res_exec.status = STS_FIELDS_FULL;
                    res_exec.count  = OCNT_W'(open_count_reg);
                    res_exec.length = open_len_reg;
                end
                else
                begin
                    res_exec.status = STS_OK;
                    res_exec.offset = open_len_reg;
                    res_exec.count  = OCNT_W'(open_count_reg + CNT_W'(1));
                    res_exec.length = app_len;
                    app_upd         = 1'b1;
                    app_wr          = 1'b1;
                end
            end
            OP_COMMIT:
            begin
                if (!open_flag_reg)
                begin
                    res_exec.status = STS_NONE_OPEN;
                end
                else
                begin
                    clr_open        = 1'b1;
                    res_exec.count  = OCNT_W'(open_count_reg);
                    res_exec.length = open_len_reg;
                    if (found_reg)
                    begin
                        res_exec.status = STS_PRESENT;
                    end
                    else
                    begin
                        res_exec.status = STS_OK;
                        cell_wr         = 1'b1;
                    end
                end
            end
            OP_QUERY:
            begin
                if (!found_reg)
                begin
                    res_exec.status = STS_NOT_FOUND;
                end
                else if (bad_index)
                begin
                    res_exec.status = STS_BAD_INDEX;
                    res_exec.count  = OCNT_W'(found_count_reg);
                    res_exec.length = found_len_reg;
                end
                else
                begin
                    start_read = 1'b1;
                end
            end
            default:
            begin
                res_exec = '0;
            end
        endcase
    end

    assign exec_fire = (state_reg == ST_EXEC) && (start_read || out_free);
    assign load_exec = (state_reg == ST_EXEC) && !start_read && out_free;
    assign load_read = (state_reg == ST_READ) && out_free;
    assign mem_we    = exec_fire && app_wr;
    assign mem_re    = exec_fire && start_read;

    assign slot_sel  = (op_reg == OP_QUERY) ? found_slot_reg : open_slot_reg;
    assign idx_sel   = (op_reg == OP_QUERY) ? ADDR_W'(fidx_reg) : ADDR_W'(open_count_reg);
    assign mem_addr  = ADDR_W'(32'(slot_sel) * MAX_FIELDS) + idx_sel;

    assign mem_wdata.ftype  = ftype_reg;
    assign mem_wdata.flen   = flen_reg;
    assign mem_wdata.offset = open_len_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        res_read        = '0;
        res_read.status = STS_OK;
        res_read.offset = rdata_reg.offset;
        res_read.count  = OCNT_W'(found_count_reg);
        res_read.length = found_len_reg;
        res_read.ftype  = rdata_reg.ftype;
        res_read.flen   = rdata_reg.flen;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = start_read ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            open_flag_reg <= 1'b0;
            open_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire && set_open)
            begin
                open_flag_reg <= 1'b1;
                open_slot_reg <= free_slot_reg;
            end
            else if (exec_fire && clr_open)
            begin
                open_flag_reg <= 1'b0;
            end
            if (load_exec || load_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= s_tuser;
            src_reg   <= s_tdata[31:0];
            tid_reg   <= s_tdata[47:32];
            ftype_reg <= s_tdata[63:48];
            flen_reg  <= s_tdata[79:64];
            fidx_reg  <= s_tdata[87:80];
        end
        if (state_reg == ST_GATHER)
        begin
            found_reg       <= g_found;
            found_slot_reg  <= g_slot;
            found_count_reg <= g_count;
            found_len_reg   <= g_len;
            free_any_reg    <= free_chain[TEMPLATES];
            free_slot_reg   <= g_take_slot;
        end
        if (exec_fire && set_open)
        begin
            open_src_reg   <= src_reg;
            open_tid_reg   <= tid_reg;
            open_count_reg <= '0;
            open_len_reg   <= '0;
        end
        else if (exec_fire && app_upd)
        begin
            open_count_reg <= open_count_reg + CNT_W'(1);
            open_len_reg   <= app_len;
        end
        if (load_exec)
        begin
            out_reg <= res_exec;
        end
        else if (load_read)
        begin
            out_reg <= res_read;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.flen, out_reg.ftype, out_reg.length, out_reg.count, out_reg.offset};

`ifndef SYNTHESIS
    a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |-> $onehot0(hit_vec))
        else $error("more than one slot matches the key");

    a_take_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(take_vec))
        else $error("more than one slot marked as lowest free");

    a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == ST_READ))
        else $error("field read not followed by read state");

    a_open_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(open_flag_reg) |-> ($past(state_reg) == ST_EXEC) && ($past(op_reg) == OP_OPEN))
        else $error("template opened outside an open item");

    a_cell_write: assert property (@(posedge clk) disable iff (!rst_n)
        (|cell_we) |-> (state_reg == ST_EXEC) && (op_reg == OP_COMMIT) && open_flag_reg
                       && !found_reg)
        else $error("slot written outside a clean commit");
`endif

endmodule

[test/flow_template_cache_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for flow_template_cache_core: opens, appends, commits and queries
// templates on the stream ports and compares every output word with a behavioral cache.
// Depends on ftc_pkg and the flow_template_cache_core RTL.
module flow_template_cache_core_tb;

    import ftc_pkg::*;

    localparam int SLOTS        = DEF_TEMPLATES;
    localparam int FIELDS_PER   = DEF_MAX_FIELDS;
    localparam int RANDOM_WORDS = 1300;
    localparam int PHASE_WORDS  = 330;
    localparam int DRAIN_AT     = 700;
    localparam int HOLD_AT      = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [OP_W-1:0]   op;
        ftc_key_t          key;
        logic [TYPE_W-1:0] ftype;
        logic [FLEN_W-1:0] flen;
        logic [FIDX_W-1:0] fidx;
    } cache_cmd_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    cache_cmd_t  stim_words[$];
    ftc_result_t pending_results[$];
    ftc_key_t    known_keys[$];

    bit                 tbl_valid [SLOTS];
    logic [SRC_W-1:0]   tbl_src   [SLOTS];
    logic [TID_W-1:0]   tbl_tid   [SLOTS];
    logic [OCNT_W-1:0]  tbl_cnt   [SLOTS];
    logic [LEN_W-1:0]   tbl_len   [SLOTS];
    ftc_field_t         tbl_fields[SLOTS*FIELDS_PER];
    bit                 open_on;
    int                 open_idx;

    int total_words;
    int words_in;
    int words_out;
    int mismatches;
    int quiet_cycles;
    int hold_left;
    int status_seen[8];
    bit hold_done;
    bit drain_done;
    bit word_taken;

    flow_template_cache_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_slot(logic [SRC_W-1:0] src, logic [TID_W-1:0] tid);
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_src[i] == src && tbl_tid[i] == tid)
                return i;
        end
        return -1;
    endfunction

    function automatic ftc_result_t cache_step(logic [OP_W-1:0] op, logic [SRC_W-1:0] src,
                                               logic [TID_W-1:0] tid,
                                               logic [TYPE_W-1:0] ftype,
                                               logic [FLEN_W-1:0] flen,
                                               logic [FIDX_W-1:0] fidx);
        ftc_result_t       res;
        int                slot;
        int                i;
        logic [OCNT_W-1:0] cnt;
        logic [LEN_W:0]    sum;
        res = '0;
        case (op)
            OP_OPEN:
            begin
                if (find_slot(src, tid) >= 0)
                    res.status = STS_PRESENT;
                else
                begin
                    slot = -1;
                    for (i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (!tbl_valid[i])
                            slot = i;
                    end
                    if (slot < 0)
                        res.status = STS_TABLE_FULL;
                    else
                    begin
                        tbl_src[slot] = src;
                        tbl_tid[slot] = tid;
                        tbl_cnt[slot] = '0;
                        tbl_len[slot] = '0;
                        open_on       = 1'b1;
                        open_idx      = slot;
                        res.status    = STS_OK;
                    end
                end
            end
            OP_APPEND, OP_COMMIT:
            begin
                if (!open_on)
                    res.status = STS_NONE_OPEN;
                else if (op == OP_APPEND)
                begin
                    cnt        = tbl_cnt[open_idx];
                    res.length = tbl_len[open_idx];
                    res.count  = cnt;
                    if (cnt >= FIELDS_PER)
                        res.status = STS_FIELDS_FULL;
                    else
                    begin
                        tbl_fields[open_idx*FIELDS_PER + cnt] = {ftype, flen, tbl_len[open_idx]};
                        sum = {1'b0, tbl_len[open_idx]} + (LEN_W + 1)'(flen);
                        if (sum > {1'b0, LEN_MAX})
                            sum = {1'b0, LEN_MAX};
                        res.status        = STS_OK;
                        res.offset        = tbl_len[open_idx];
                        tbl_cnt[open_idx] = cnt + 1'b1;
                        tbl_len[open_idx] = sum[LEN_W-1:0];
                        res.count         = tbl_cnt[open_idx];
                        res.length        = tbl_len[open_idx];
                    end
                end
                else
                begin
                    open_on    = 1'b0;
                    res.count  = tbl_cnt[open_idx];
                    res.length = tbl_len[open_idx];
                    if (find_slot(tbl_src[open_idx], tbl_tid[open_idx]) >= 0)
                        res.status = STS_PRESENT;
                    else
                    begin
                        tbl_valid[open_idx] = 1'b1;
                        res.status          = STS_OK;
                    end
                end
            end
            default:
            begin
                slot = find_slot(src, tid);
                if (slot < 0)
                    res.status = STS_NOT_FOUND;
                else
                begin
                    res.count  = tbl_cnt[slot];
                    res.length = tbl_len[slot];
                    if (fidx >= tbl_cnt[slot] || fidx >= FIELDS_PER)
                        res.status = STS_BAD_INDEX;
                    else
                    begin
                        res.status = STS_OK;
                        res.offset = tbl_fields[slot*FIELDS_PER + fidx].offset;
                        res.ftype  = tbl_fields[slot*FIELDS_PER + fidx].ftype;
                        res.flen   = tbl_fields[slot*FIELDS_PER + fidx].flen;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic push_cmd(logic [OP_W-1:0] op, ftc_key_t key, logic [TYPE_W-1:0] ftype,
                            logic [FLEN_W-1:0] flen, logic [FIDX_W-1:0] fidx);
        cache_cmd_t cmd;
        cmd.op    = op;
        cmd.key   = key;
        cmd.ftype = ftype;
        cmd.flen  = flen;
        cmd.fidx  = fidx;
        stim_words = {stim_words, cmd};
    endtask

    task automatic push_rand(logic [OP_W-1:0] op, ftc_key_t key);
        push_cmd(op, key, TYPE_W'($urandom), FLEN_W'($urandom), FIDX_W'($urandom));
    endtask

    function automatic ftc_key_t fresh_key();
        ftc_key_t k;
        if ($urandom_range(9) == 0)
        begin
            k.src = $urandom_range(3);
            k.tid = TID_W'($urandom_range(3));
        end
        else
        begin
            k.src = $urandom;
            k.tid = TID_W'($urandom_range(65535));
        end
        return k;
    endfunction

    function automatic ftc_key_t old_key();
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    task automatic note_mismatch(string what, logic [95:0] want, logic [95:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at output word %0d: %s expected %0h, got %0h",
                     words_out, what, want, got);
    endtask

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        ftc_result_t got;
        ftc_result_t want;
        ftc_result_t pred;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pred = cache_step(s_tuser, s_tdata[31:0], s_tdata[47:32],
                                  s_tdata[63:48], s_tdata[79:64], s_tdata[87:80]);
                pending_results = {pending_results, pred};
                words_in++;
                word_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[20:0], m_tdata[26:21], m_tdata[47:27],
                       m_tdata[63:48], m_tdata[79:64]};
                words_out++;
                status_seen[m_tuser]++;
                if (pending_results.size() == 0)
                    note_mismatch("word with nothing pending", '0, 96'(got));
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        note_mismatch("status", 96'(want.status), 96'(got.status));
                    if (got.offset != want.offset)
                        note_mismatch("field_offset", 96'(want.offset), 96'(got.offset));
                    if (got.count != want.count)
                        note_mismatch("field_count", 96'(want.count), 96'(got.count));
                    if (got.length != want.length)
                        note_mismatch("record_length", 96'(want.length), 96'(got.length));
                    if (got.ftype != want.ftype)
                        note_mismatch("found_type", 96'(want.ftype), 96'(got.ftype));
                    if (got.flen != want.flen)
                        note_mismatch("found_length", 96'(want.flen), 96'(got.flen));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // driver: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        cache_cmd_t cmd;
        int         mode;
        bit         hold;
        mode = (words_in / PHASE_WORDS) % 4;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || word_taken)
        begin
            word_taken = 1'b0;
            if (!drain_done && words_in >= DRAIN_AT && pending_results.size() == 0)
                drain_done = 1'b1;
            hold = (!drain_done && words_in >= DRAIN_AT)
                || (mode == 1 && $urandom_range(99) < 79)
                || (mode == 3 && $urandom_range(99) < 16);
            if (stim_words.size() == 0 || hold)
                s_tvalid <= 1'b0;
            else
            begin
                cmd = stim_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cmd.fidx, cmd.flen, cmd.ftype, cmd.key.tid, cmd.key.src};
                s_tuser  <= cmd.op;
            end
        end
    end

    // receiver: random stalls per phase, one long hold-off
    always @(negedge clk)
    begin
        int mode;
        mode = (words_in / PHASE_WORDS) % 4;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && words_out >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (mode == 2)
            m_tready <= ($urandom_range(99) >= 79);
        else if (mode == 3)
            m_tready <= ($urandom_range(99) >= 16);
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        ftc_key_t key_hi;
        ftc_key_t key_lo;
        ftc_key_t key_mid;
        ftc_key_t key;
        int       directed;
        int       pick;
        int       nf;
        int       roll;

        key_hi  = '{src: 32'hFFFF_FFFF, tid: 16'hFFFF};
        key_lo  = '{src: 32'h0, tid: 16'h0};
        key_mid = '{src: 32'h8000_0000, tid: 16'h8000};

        push_cmd(OP_APPEND, key_lo, 16'hFFFF, 16'hFFFF, 8'h0);
        push_cmd(OP_COMMIT, key_lo, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_QUERY, key_hi, 16'h0, 16'h0, 8'hFF);
        push_cmd(OP_OPEN, key_hi, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_APPEND, key_lo, 16'hFFFF, 16'hFFFF, 8'h0);
        push_cmd(OP_APPEND, key_hi, 16'h0, 16'h0, 8'hFF);
        push_cmd(OP_APPEND, key_lo, 16'h1234, 16'd10, 8'h0);
        push_cmd(OP_COMMIT, key_lo, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_QUERY, key_hi, 16'h0, 16'h0, 8'd0);
        push_cmd(OP_QUERY, key_hi, 16'h0, 16'h0, 8'd2);
        push_cmd(OP_QUERY, key_hi, 16'h0, 16'h0, 8'd3);
        push_cmd(OP_QUERY, key_hi, 16'h0, 16'h0, 8'hFF);
        push_cmd(OP_OPEN, key_hi, 16'h0, 16'h0, 8'h0);
        // abandon an open template by opening another
        push_cmd(OP_OPEN, key_lo, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_APPEND, key_lo, 16'h00FF, 16'd4, 8'h0);
        push_cmd(OP_OPEN, key_mid, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_APPEND, key_lo, 16'hFF00, 16'd2, 8'h0);
        push_cmd(OP_COMMIT, key_lo, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_QUERY, key_lo, 16'h0, 16'h0, 8'd0);
        push_cmd(OP_QUERY, key_mid, 16'h0, 16'h0, 8'd0);
        // template with no fields
        push_cmd(OP_OPEN, key_lo, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_COMMIT, key_hi, 16'h0, 16'h0, 8'h0);
        push_cmd(OP_QUERY, key_lo, 16'h0, 16'h0, 8'd0);
        known_keys = {known_keys, key_hi};
        known_keys = {known_keys, key_lo};
        known_keys = {known_keys, key_mid};
        directed = stim_words.size();

        while (stim_words.size() < directed + RANDOM_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                if ($urandom_range(99) < 70)
                begin
                    key = fresh_key();
                    known_keys = {known_keys, key};
                end
                else
                    key = old_key();
                if ($urandom_range(99) < 8)
                begin
                    push_rand(OP_OPEN, fresh_key());
                    push_rand(OP_APPEND, fresh_key());
                end
                roll = $urandom_range(99);
                if (roll < 90)
                    nf = $urandom_range(8);
                else if (roll < 97)
                    nf = $urandom_range(FIELDS_PER + 2, FIELDS_PER - 1);
                else
                    nf = $urandom_range(FIELDS_PER - 2, 9);
                push_rand(OP_OPEN, key);
                repeat (nf)
                    push_rand(OP_APPEND, fresh_key());
                if ($urandom_range(99) < 92)
                    push_rand(OP_COMMIT, fresh_key());
            end
            else if (pick < 85)
            begin
                key  = ($urandom_range(99) < 85) ? old_key() : fresh_key();
                roll = $urandom_range(99);
                push_cmd(OP_QUERY, key, TYPE_W'($urandom), FLEN_W'($urandom),
                         FIDX_W'((roll < 80) ? $urandom_range(9) :
                                 (roll < 90) ? $urandom_range(FIELDS_PER + 1, FIELDS_PER - 2) :
                                               $urandom_range(255)));
            end
            else
                push_rand(OP_W'($urandom_range(3)), fresh_key());
        end
        total_words = stim_words.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (words_in == total_words);
        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);

        $display("Ran %0d words through four pacing phases, a drain pause and a long output hold.",
                 words_out);
        $display("Status counts 0..6: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[STS_OK], status_seen[STS_PRESENT], status_seen[STS_TABLE_FULL],
                 status_seen[STS_NOT_FOUND], status_seen[STS_BAD_INDEX],
                 status_seen[STS_NONE_OPEN], status_seen[STS_FIELDS_FULL]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
